// File: sv/pngcrc_pkg.sv
// Shared types, constants and CRC helpers for the PNG signature and chunk CRC repair block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package pngcrc_pkg;

  // Reflected CRC-32 polynomial and the all-ones init / final xor value
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // Chunk type that closes the file
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  // Header field sizes, in bytes
  localparam int unsigned SIG_BYTES = 8;
  localparam int unsigned LEN_BYTES = 4;

  // Walk phase, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  // One input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_changed;
    logic       crc_checked;
    logic       crc_was_bad;
    logic       after_end;
    logic       file_repaired;
    logic       out_last;
  } result_t;

  // PNG signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      3'd7:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Advance the reflected CRC-32 by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

`default_nettype wire

// File: sv/pngcrc_in_reg.sv
// Input register stage of the PNG chunk CRC repair block: holds one accepted word.
// Depends on pngcrc_pkg for the input word type.
`default_nettype none

module pngcrc_in_reg (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire pngcrc_pkg::in_item_t item_i,
  input  wire                   advance_i,
  output logic                  valid_o,
  output pngcrc_pkg::in_item_t  item_o
);
  import pngcrc_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Stall while a held word cannot move on this cycle
  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: sv/pngcrc_engine.sv
// Chunk walker of the PNG chunk CRC repair block: file state and the per-byte repair logic.
// Depends on pngcrc_pkg for the phase encoding, word types and CRC step.
`default_nettype none

module pngcrc_engine (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   advance_i,
  input  wire pngcrc_pkg::in_item_t item_i,
  output pngcrc_pkg::result_t   result_o
);
  import pngcrc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic        any_q, any_d;
  logic        mism_q, mism_d;

  logic [32:0] cnt_inc;
  logic [31:0] crc_fin;
  logic [31:0] crc_step;
  logic [7:0]  b;
  logic [7:0]  ob;
  logic        changed;
  logic        checked;
  logic        bad;
  logic        after;

  assign b        = item_i.in_byte;
  assign cnt_inc  = {1'b0, cnt_q} + 33'd1;
  assign crc_fin  = crc_q ^ CRC_ONES;
  assign crc_step = crc_byte(crc_q, b);

  // Next state and result for the word in the input register
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    type_d  = type_q;
    crc_d   = crc_q;
    mism_d  = mism_q;
    ob      = b;
    checked = 1'b0;
    bad     = 1'b0;
    after   = 1'b0;

    case (phase_q)
      PH_SIG: begin
        ob    = sig_byte(cnt_q[2:0]);
        cnt_d = cnt_inc[31:0];
        if (cnt_inc >= 33'(SIG_BYTES)) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end
      end
      PH_LEN: begin
        len_d = {len_q[23:0], b};
        cnt_d = cnt_inc[31:0];
        if (cnt_inc >= 33'(LEN_BYTES)) begin
          phase_d = PH_TYPE;
          cnt_d   = '0;
          crc_d   = CRC_ONES;
          type_d  = '0;
          mism_d  = 1'b0;
        end
      end
      PH_TYPE: begin
        type_d = {type_q[23:0], b};
        crc_d  = crc_step;
        cnt_d  = cnt_inc[31:0];
        if (cnt_inc >= 33'(LEN_BYTES)) begin
          cnt_d   = '0;
          phase_d = (len_q == '0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_d = crc_step;
        cnt_d = cnt_inc[31:0];
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = PH_CRC;
          cnt_d   = '0;
        end
      end
      PH_CRC: begin
        // Replace stored CRC bytes, most significant first
        case (cnt_q[1:0])
          2'd0:    ob = crc_fin[31:24];
          2'd1:    ob = crc_fin[23:16];
          2'd2:    ob = crc_fin[15:8];
          default: ob = crc_fin[7:0];
        endcase
        mism_d = mism_q | (ob != b);
        cnt_d  = cnt_inc[31:0];
        if (cnt_inc >= 33'(LEN_BYTES)) begin
          checked = 1'b1;
          bad     = mism_d;
          cnt_d   = '0;
          len_d   = '0;
          mism_d  = 1'b0;
          phase_d = (type_q == TYPE_IEND) ? PH_DONE : PH_LEN;
        end
      end
      PH_DONE: begin
        after = 1'b1;
      end
      default: begin
        after   = 1'b1;
        phase_d = PH_SIG;
      end
    endcase

    changed = (ob != b);
    any_d   = any_q | changed;

    // Drop all file state after the final byte
    if (item_i.in_last) begin
      phase_d = PH_SIG;
      cnt_d   = '0;
      len_d   = '0;
      type_d  = '0;
      crc_d   = CRC_ONES;
      mism_d  = 1'b0;
    end
  end

  always_comb begin
    result_o.out_byte      = ob;
    result_o.byte_changed  = changed;
    result_o.crc_checked   = checked;
    result_o.crc_was_bad   = bad;
    result_o.after_end     = after;
    result_o.file_repaired = item_i.in_last & any_d;
    result_o.out_last      = item_i.in_last;
  end

  // Commit state as the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      cnt_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      crc_q   <= CRC_ONES;
      any_q   <= 1'b0;
      mism_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      any_q   <= item_i.in_last ? 1'b0 : any_d;
      mism_q  <= mism_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/pngcrc_out_reg.sv
// Result register stage of the PNG chunk CRC repair block: holds one result word for the sink.
// Depends on pngcrc_pkg for the result word type.
`default_nettype none

module pngcrc_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  src_valid_i,
  input  wire pngcrc_pkg::result_t result_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output pngcrc_pkg::result_t  result_o
);
  import pngcrc_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Move a word in when the register is empty or being drained
  assign advance_o = src_valid_i & (~valid_q | ~out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// File: sv/png_signature_and_chunk_crc_repair_top.sv
// Top level of the PNG signature and chunk CRC repair block.
// Depends on pngcrc_pkg, pngcrc_in_reg, pngcrc_engine and pngcrc_out_reg.
`default_nettype none

// Takes a PNG file one byte per word and returns one repaired byte per word: the first eight
// bytes become the PNG signature, each chunk's four stored CRC bytes are replaced by the CRC-32
// computed over its type and data, and bytes after IEND pass unchanged. in_last ends a file and
// returns the block to its start state. The block takes one byte every cycle while the sink does not
// stall, and each accepted word passes through the input register and then the result register
// to the output. A stalled sink fills the result register and then the input register, after
// which the input stalls. The byte-wide CRC-32 step in the chunk walker, between the input
// register and the result register, sets the clock period. No clearing pass follows reset.
module png_signature_and_chunk_crc_repair_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] in_byte_i,
  input  wire        in_last_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_changed_o,
  output logic       crc_checked_o,
  output logic       crc_was_bad_o,
  output logic       after_end_o,
  output logic       file_repaired_o,
  output logic       out_last_o
);
  import pngcrc_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     advance;
  result_t  eng_result;
  result_t  out_result;

  assign in_item.in_byte = in_byte_i;
  assign in_item.in_last = in_last_i;

  pngcrc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  pngcrc_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .result_o  (eng_result)
  );

  pngcrc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (held_valid),
    .result_i    (eng_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign out_byte_o      = out_result.out_byte;
  assign byte_changed_o  = out_result.byte_changed;
  assign crc_checked_o   = out_result.crc_checked;
  assign crc_was_bad_o   = out_result.crc_was_bad;
  assign after_end_o     = out_result.after_end;
  assign file_repaired_o = out_result.file_repaired;
  assign out_last_o      = out_result.out_last;

  // A mismatch is only reported on the closing CRC byte
  a_bad_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_was_bad_o |-> crc_checked_o)
    else $error("crc_was_bad without crc_checked");

  // Bytes after IEND never carry a CRC check
  a_after_no_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && after_end_o |-> !crc_checked_o && !byte_changed_o)
    else $error("check or change after end of file");

  // The repair summary only appears on the final byte
  a_repaired_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_repaired_o |-> out_last_o)
    else $error("file_repaired away from the final byte");

  // A full input register behind a stalled result register must stall the source
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && out_valid_o && out_stall_i |-> in_stall_o && !advance)
    else $error("input not stalled while both stages are full");

endmodule

`default_nettype wire
